[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the roi block qp map rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define RBQM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define RBQM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[hw/rtl/rbqm_pkg.sv]
// ----------------------------------------------------------------------------
// rbqm_pkg
// types, constants and codes shared by the roi block qp map modules
// ----------------------------------------------------------------------------
package rbqm_pkg;

   // default table depth and map size
   localparam int DEF_MAX_REGIONS = 16;
   localparam int MAX_MAP_BLOCKS  = 1024;
   localparam int MAP_CMP_W       = $clog2(MAX_MAP_BLOCKS + 1) > 10 ?
                                    $clog2(MAX_MAP_BLOCKS + 1) : 10;

   // region entries compared side by side in one scan step
   localparam int LANE_BITS = 4;
   localparam int LANES     = 1 << LANE_BITS;

   // queue depths
   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 2;

   // field widths
   localparam int IDX_W   = 4;
   localparam int EDGE_W  = 14;
   localparam int LIMIT_W = 15;
   localparam int DELTA_W = 7;
   localparam int BLK_W   = 10;
   localparam int SIZE_W  = 7;
   localparam int PIX_W   = BLK_W + SIZE_W;
   localparam int QP_W    = 6;
   localparam int COUNT_W = 5;
   localparam int OUT_W   = 8;
   localparam int CSR_W   = 7;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      CSR_BLOCK_WIDTH  = 2'd0,
      CSR_BLOCK_HEIGHT = 2'd1,
      CSR_BASE_QP      = 2'd2,
      CSR_REGION_COUNT = 2'd3
   } csr_index_type;

   typedef enum logic {
      SCAN_IDLE = 1'b0,
      SCAN_BUSY = 1'b1
   } scan_state_type;

   // configuration registers as seen by front and back
   typedef struct packed {
      logic [SIZE_W-1:0]  block_width;
      logic [SIZE_W-1:0]  block_height;
      logic [QP_W-1:0]    base_qp;
      logic [COUNT_W-1:0] region_count;
   } cfg_type;

   // one stored region
   typedef struct packed {
      logic [EDGE_W-1:0]         left;
      logic [EDGE_W-1:0]         top;
      logic [LIMIT_W-1:0]        right;
      logic [LIMIT_W-1:0]        bottom;
      logic signed [DELTA_W-1:0] delta;
   } entry_type;

   // classified item passed from front to back
   typedef struct packed {
      op_type             kind;
      logic [IDX_W-1:0]   region_index;
      entry_type          entry;
      logic [PIX_W-1:0]   px;
      logic [PIX_W-1:0]   py;
   } cmd_type;

   // one result
   typedef struct packed {
      logic signed [OUT_W-1:0] block_qp;
      logic                    region_hit;
   } rsp_type;

endpackage

[hw/rtl/rbqm_fifo.sv]
// ----------------------------------------------------------------------------
// rbqm_fifo
// small register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
module rbqm_fifo #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] wr_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] rd_data,
   output logic              empty
);
   localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = count_ff == CW'(DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[hw/rtl/rbqm_front.sv]
// ----------------------------------------------------------------------------
// rbqm_front
// accepts items, drops off-map queries and turns block indexes into pixels
// ----------------------------------------------------------------------------
module rbqm_front (
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic                                  req_opcode,
   input  logic [rbqm_pkg::IDX_W-1:0]            req_region_index,
   input  logic [rbqm_pkg::EDGE_W-1:0]           req_rect_left,
   input  logic [rbqm_pkg::EDGE_W-1:0]           req_rect_top,
   input  logic [rbqm_pkg::LIMIT_W-1:0]          req_rect_right,
   input  logic [rbqm_pkg::LIMIT_W-1:0]          req_rect_bottom,
   input  logic signed [rbqm_pkg::DELTA_W-1:0]   req_delta_qp,
   input  logic [rbqm_pkg::BLK_W-1:0]            req_block_col,
   input  logic [rbqm_pkg::BLK_W-1:0]            req_block_row,
   input  rbqm_pkg::cfg_type                     cfg,
   output logic                                  cmd_push,
   output rbqm_pkg::cmd_type                     cmd_data,
   input  logic                                  cmd_full
);
   import rbqm_pkg::*;

   op_type kind;
   logic   in_map;

   assign kind     = op_type'(req_opcode);
   assign in_map   = (MAP_CMP_W'(req_block_col) < MAP_CMP_W'(MAX_MAP_BLOCKS)) &&
                     (MAP_CMP_W'(req_block_row) < MAP_CMP_W'(MAX_MAP_BLOCKS));
   assign req_full = cmd_full;

   // queries outside the map are taken but produce nothing
   assign cmd_push = req_push && !cmd_full && (kind == OP_WRITE || in_map);

   // block origin in pixels, registered in the command queue
   always_comb begin
      cmd_data.kind         = kind;
      cmd_data.region_index = req_region_index;
      cmd_data.entry.left   = req_rect_left;
      cmd_data.entry.top    = req_rect_top;
      cmd_data.entry.right  = req_rect_right;
      cmd_data.entry.bottom = req_rect_bottom;
      cmd_data.entry.delta  = req_delta_qp;
      cmd_data.px           = PIX_W'(req_block_col) * PIX_W'(cfg.block_width);
      cmd_data.py           = PIX_W'(req_block_row) * PIX_W'(cfg.block_height);
   end

endmodule

[hw/rtl/rbqm_back.sv]
// ----------------------------------------------------------------------------
// rbqm_back
// region table and scanner: applies writes, searches regions for queries
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbqm_back #(
   parameter int MAX_REGIONS = rbqm_pkg::DEF_MAX_REGIONS
) (
   input  logic              clock,
   input  logic              reset,
   input  rbqm_pkg::cfg_type cfg,
   input  rbqm_pkg::cmd_type cmd_head,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   output logic              rsp_push,
   output rbqm_pkg::rsp_type rsp_data,
   input  logic              rsp_full
);
   import rbqm_pkg::*;

   localparam int ROWS = (MAX_REGIONS + LANES - 1) / LANES;
   localparam int RW   = ROWS > 1 ? $clog2(ROWS) : 1;
   localparam int IW   = RW + LANE_BITS;
   localparam int NW   = $clog2(MAX_REGIONS + 1) > COUNT_W ?
                         $clog2(MAX_REGIONS + 1) : COUNT_W;
   localparam int CW   = (IW > NW ? IW : NW) + 1;

   scan_state_type       state_ff, state_in;
   logic [RW-1:0]        row_ff, row_in;
   logic [PIX_W-1:0]     px_ff, px_in;
   logic [PIX_W-1:0]     py_ff, py_in;
   logic [RW-1:0]        rd_addr;
   logic                 wr_en;
   logic                 wr_ok;
   logic [IW-1:0]        wr_idx;
   logic [LANE_BITS-1:0] wr_lane;
   logic [RW-1:0]        wr_row;
   logic [NW-1:0]        n_eff;
   logic [NW-1:0]        n_m1;
   logic [RW-1:0]        last_row;
   entry_type            lane_data [LANES];
   logic [LANES-1:0]     lane_match;
   logic                 any_hit;
   logic signed [DELTA_W-1:0] sel_delta;
   logic                 scan_done;
   logic                 pop_query;

   // searched entry count, capped at the table size
   assign n_eff    = (NW'(cfg.region_count) > NW'(MAX_REGIONS)) ?
                     NW'(MAX_REGIONS) : NW'(cfg.region_count);
   assign n_m1     = n_eff - 1'b1;
   assign last_row = (n_eff == '0) ? '0 : RW'(n_m1 >> LANE_BITS);

   // write address split into lane and row
   assign wr_idx  = IW'(cmd_head.region_index);
   assign wr_ok   = CW'(wr_idx) < CW'(MAX_REGIONS);
   assign wr_lane = wr_idx[LANE_BITS-1:0];
   assign wr_row  = wr_idx[IW-1:LANE_BITS];

   // one table memory per lane, registered read
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      entry_type mem_ff [ROWS];
      entry_type rd_data_ff;

      always_ff @(posedge clock) begin
         if (wr_en && wr_lane == LANE_BITS'(g)) begin
            mem_ff[wr_row] <= cmd_head.entry;
         end
         rd_data_ff <= mem_ff[rd_addr];
      end

      assign lane_data[g] = rd_data_ff;
   end

   // containment test per lane for the row just read
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         lane_match[k] = (CW'({row_ff, LANE_BITS'(k)}) < CW'(n_eff)) &&
                         (px_ff >= PIX_W'(lane_data[k].left)) &&
                         (px_ff <  PIX_W'(lane_data[k].right)) &&
                         (py_ff >= PIX_W'(lane_data[k].top)) &&
                         (py_ff <  PIX_W'(lane_data[k].bottom));
      end
   end

   // lowest matching lane wins
   always_comb begin
      any_hit   = 1'b0;
      sel_delta = '0;
      for (int k = LANES - 1; k >= 0; k--) begin
         if (lane_match[k]) begin
            any_hit   = 1'b1;
            sel_delta = lane_data[k].delta;
         end
      end
   end

   assign scan_done = any_hit || (row_ff == last_row);

   // result word
   always_comb begin
      rsp_data.region_hit = any_hit;
      rsp_data.block_qp   = any_hit ?
                            OUT_W'(cfg.base_qp) + {sel_delta[DELTA_W-1], sel_delta} :
                            OUT_W'(cfg.base_qp);
   end

   // scan sequencer
   always_comb begin
      logic take;
      take     = 1'b0;
      state_in = state_ff;
      row_in   = row_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      rd_addr  = row_ff;
      cmd_pop  = 1'b0;
      wr_en    = 1'b0;
      rsp_push = 1'b0;
      unique case (state_ff)
         SCAN_IDLE: begin
            take = 1'b1;
         end
         SCAN_BUSY: begin
            if (!scan_done) begin
               row_in  = row_ff + 1'b1;
               rd_addr = row_ff + 1'b1;
            end else if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = SCAN_IDLE;
               take     = 1'b1;
            end
         end
      endcase
      if (take && !cmd_empty) begin
         cmd_pop = 1'b1;
         if (cmd_head.kind == OP_WRITE) begin
            wr_en = wr_ok;
         end else begin
            state_in = SCAN_BUSY;
            row_in   = '0;
            rd_addr  = '0;
            px_in    = cmd_head.px;
            py_in    = cmd_head.py;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCAN_IDLE;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
      end
   end

   // block origin of the query in flight
   always_ff @(posedge clock) begin
      px_ff <= px_in;
      py_ff <= py_in;
   end

   assign pop_query = cmd_pop && cmd_head.kind == OP_QUERY;

   `RBQM_ASSERT_IMPLY(a_pop_needs_item, clock, reset, cmd_pop, !cmd_empty)
   `RBQM_ASSERT_IMPLY(a_row_in_range, clock, reset, state_ff == SCAN_BUSY, row_ff <= last_row)
   `RBQM_ASSERT_IMPLY(a_write_not_mid_scan, clock, reset, wr_en, state_ff == SCAN_IDLE || scan_done)
   `RBQM_ASSERT_NEXT(a_query_starts_scan, clock, reset, pop_query, state_ff == SCAN_BUSY && row_ff == '0)

endmodule

[hw/rtl/roi_block_qp_map.sv]
// ----------------------------------------------------------------------------
// roi_block_qp_map
// region-of-interest qp map: region table writes and per-block qp queries
// ----------------------------------------------------------------------------
// usage
//   req_*: input queue side. an item is taken when req_push is high and
//   req_full is low. opcode write loads one region entry and gives no result;
//   opcode query gives one result on the rsp_* side.
//   rsp_*: result queue side. the oldest result is on the ports while
//   rsp_empty is low and is taken when rsp_pop is high.
//   csr_*: register writes, always ready; write only while the block is idle.
// timing
//   a query result passes the command queue, the registered table read and
//   the result queue on its way to rsp_*. items move at one per cycle while
//   the result queue has room; a query holds the scanner for each row of 16
//   searched entries up to the first hit, at least one (one row by default).
// reset
//   registers return to their defaults, both queues empty, the region table
//   is undefined until written. when the receiver stalls the result queue
//   fills, the scanner holds and req_full rises once the command queue fills.
// ----------------------------------------------------------------------------
module roi_block_qp_map #(
   parameter int MAX_REGIONS = rbqm_pkg::DEF_MAX_REGIONS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic                                  req_opcode,
   input  logic [rbqm_pkg::IDX_W-1:0]            req_region_index,
   input  logic [rbqm_pkg::EDGE_W-1:0]           req_rect_left,
   input  logic [rbqm_pkg::EDGE_W-1:0]           req_rect_top,
   input  logic [rbqm_pkg::LIMIT_W-1:0]          req_rect_right,
   input  logic [rbqm_pkg::LIMIT_W-1:0]          req_rect_bottom,
   input  logic signed [rbqm_pkg::DELTA_W-1:0]   req_delta_qp,
   input  logic [rbqm_pkg::BLK_W-1:0]            req_block_col,
   input  logic [rbqm_pkg::BLK_W-1:0]            req_block_row,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic signed [rbqm_pkg::OUT_W-1:0]     rsp_block_qp,
   output logic                                  rsp_region_hit,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [1:0]                            csr_index,
   input  logic [rbqm_pkg::CSR_W-1:0]            csr_wdata
);
   import rbqm_pkg::*;

   logic [SIZE_W-1:0]  block_width_ff;
   logic [SIZE_W-1:0]  block_height_ff;
   logic [QP_W-1:0]    base_qp_ff;
   logic [COUNT_W-1:0] region_count_ff;
   cfg_type            cfg;
   logic               cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type            cmd_wr, cmd_head;
   logic               rsp_push, rsp_full;
   rsp_type            rsp_wr, rsp_head;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_width_ff  <= SIZE_W'(16);
         block_height_ff <= SIZE_W'(16);
         base_qp_ff      <= QP_W'(26);
         region_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_BLOCK_WIDTH:  block_width_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_BLOCK_HEIGHT: block_height_ff <= csr_wdata[SIZE_W-1:0];
            CSR_BASE_QP:      base_qp_ff      <= csr_wdata[QP_W-1:0];
            CSR_REGION_COUNT: region_count_ff <= csr_wdata[COUNT_W-1:0];
         endcase
      end
   end

   always_comb begin
      cfg.block_width  = block_width_ff;
      cfg.block_height = block_height_ff;
      cfg.base_qp      = base_qp_ff;
      cfg.region_count = region_count_ff;
   end

   // front: classify and scale
   rbqm_front u_front (
      .req_push         (req_push),
      .req_full         (req_full),
      .req_opcode       (req_opcode),
      .req_region_index (req_region_index),
      .req_rect_left    (req_rect_left),
      .req_rect_top     (req_rect_top),
      .req_rect_right   (req_rect_right),
      .req_rect_bottom  (req_rect_bottom),
      .req_delta_qp     (req_delta_qp),
      .req_block_col    (req_block_col),
      .req_block_row    (req_block_row),
      .cfg              (cfg),
      .cmd_push         (cmd_push),
      .cmd_data         (cmd_wr),
      .cmd_full         (cmd_full)
   );

   // command queue between front and back
   rbqm_fifo #(
      .DATA_W ($bits(cmd_type)),
      .DEPTH  (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_wr),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_head),
      .empty   (cmd_empty)
   );

   // back: table and scanner
   rbqm_back #(
      .MAX_REGIONS (MAX_REGIONS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_head  (cmd_head),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_wr),
      .rsp_full  (rsp_full)
   );

   // result queue
   rbqm_fifo #(
      .DATA_W ($bits(rsp_type)),
      .DEPTH  (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_wr),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_head),
      .empty   (rsp_empty)
   );

   assign rsp_block_qp   = rsp_head.block_qp;
   assign rsp_region_hit = rsp_head.region_hit;

endmodule
